>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the string matcher.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge outside reset.
`define ACM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property that must hold at every rising edge outside reset.
`define ACM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

>>> src/acm_pkg.sv
// Shared types and constants of the multi-pattern string matcher.
// No dependencies; used by the top level.
`default_nettype none

package acm_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned SYM_W = 7;
  localparam int unsigned PID_W = 10;

  // Code 7 is unused; it only returns a result.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_PSYM   = 3'd1,
    OP_PEND   = 3'd2,
    OP_BUILD  = 3'd3,
    OP_TSTART = 3'd4,
    OP_TSYM   = 3'd5,
    OP_QUERY  = 3'd6
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] symbol;
    logic [PID_W-1:0] pattern_id;
  } acm_in_t;

  typedef struct packed {
    logic status;
    logic hit;
    logic any_match;
    logic seen;
  } acm_out_t;

endpackage

`default_nettype wire

>>> src/multi_pattern_string_matcher.sv
// Aho-Corasick matcher: goto table, node pattern ids, failure links, seen bits and
// the build queue each live in a single-port-read RAM (acm_ram, acm_pkg).
`default_nettype none

`include "assert_macros.svh"

// One op is handled at a time; its result goes to an output register, and the
// next op is taken while that result waits. Every memory read is registered.
// A pattern symbol reads the goto table and, when a new node is made, fills its
// goto row with the root; a text symbol follows the failure chain of the new
// state (bounded by the deepest pattern); build fills the root row, then expands
// each trie node from the queue; text start clears the seen bits; clear all
// clears the root row and the seen bits. After reset a full clearing pass runs
// before the first op is taken. An op whose result finds the output register
// still full waits until that register is taken.
module multi_pattern_string_matcher import acm_pkg::*; #(
  parameter int unsigned NODES       = 1024,
  parameter int unsigned ALPHABET    = 128,
  parameter int unsigned PATTERN_IDS = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire acm_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output acm_out_t     out_data_o
);

  localparam int unsigned NW       = $clog2(NODES);
  localparam int unsigned AW       = $clog2(ALPHABET);
  localparam int unsigned IW       = (PATTERN_IDS > 1) ? $clog2(PATTERN_IDS) : 1;
  localparam int unsigned GAW      = NW + AW;
  localparam int unsigned GDEPTH   = NODES * (2 ** AW);
  localparam int unsigned CLR_FULL = (ALPHABET > PATTERN_IDS) ? ALPHABET : PATTERN_IDS;
  localparam int unsigned CNT_W    = $clog2(CLR_FULL + 1);
  localparam int unsigned NPW      = PID_W + 1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PRD, S_ALLOC, S_B0RD, S_B0EX, S_BQRD, S_BQEX, S_BFEX,
    S_BURD, S_BFRD, S_BEX, S_TRD, S_WCHK, S_WEX, S_QRD, S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [NW-1:0]     ins_q, ins_d;
  logic [NW-1:0]     match_q, match_d;
  logic [NW:0]       ncount_q, ncount_d;
  logic              drop_q, drop_d;
  logic              any_q, any_d;
  logic              full_q, full_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NW:0]       head_q, head_d;
  logic [NW:0]       tail_q, tail_d;
  logic [NW-1:0]     u_q, u_d;
  logic [NW-1:0]     f_q, f_d;
  logic [NW:0]       e_q, e_d;
  logic [NW-1:0]     x_q, x_d;
  logic [NW:0]       steps_q, steps_d;
  logic              found_q, found_d;
  acm_out_t          rsp_q, rsp_d;
  acm_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Memory ports.
  logic              g_we;
  logic [GAW-1:0]    g_waddr, g_raddr;
  logic [NW:0]       g_wdata, g_rdata;
  logic              np_we;
  logic [NW-1:0]     np_waddr, np_raddr;
  logic [NPW-1:0]    np_wdata, np_rdata;
  logic              fl_we;
  logic [NW-1:0]     fl_waddr, fl_raddr;
  logic [NW-1:0]     fl_wdata, fl_rdata;
  logic              q_we;
  logic [NW-1:0]     q_waddr, q_raddr;
  logic [NW-1:0]     q_wdata, q_rdata;
  logic              s_we;
  logic [IW-1:0]     s_waddr, s_raddr;
  logic [0:0]        s_wdata, s_rdata;

  logic              in_fire;
  logic [AW-1:0]     cnt_sym;
  logic              alloc_start;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cnt_sym     = cnt_q[AW-1:0];
  assign alloc_start = (state_q == S_PRD) && (state_d == S_ALLOC);

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    ins_d       = ins_q;
    match_d     = match_q;
    ncount_d    = ncount_q;
    drop_d      = drop_q;
    any_d       = any_q;
    full_d      = full_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    u_d         = u_q;
    f_d         = f_q;
    e_d         = e_q;
    x_d         = x_q;
    steps_d     = steps_q;
    found_d     = found_q;
    rsp_d       = rsp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    g_we     = 1'b0;
    g_waddr  = '0;
    g_wdata  = '0;
    g_raddr  = '0;
    np_we    = 1'b0;
    np_waddr = '0;
    np_wdata = '0;
    np_raddr = x_q;
    fl_we    = 1'b0;
    fl_waddr = '0;
    fl_wdata = '0;
    fl_raddr = x_q;
    q_we     = 1'b0;
    q_waddr  = tail_q[NW-1:0];
    q_wdata  = '0;
    q_raddr  = head_q[NW-1:0];
    s_we     = 1'b0;
    s_waddr  = '0;
    s_wdata  = '0;
    s_raddr  = IW'(in_data_i.pattern_id);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        if (full_q && (cnt_q < ALPHABET)) begin
          g_we    = 1'b1;
          g_waddr = {NW'(0), cnt_sym};
        end
        if (cnt_q < PATTERN_IDS) begin
          s_we    = 1'b1;
          s_waddr = cnt_q[IW-1:0];
        end
        if (full_q && (cnt_q == '0)) begin
          np_we = 1'b1;
          fl_we = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (( full_q && (cnt_q == CNT_W'(CLR_FULL - 1))) ||
            (!full_q && (cnt_q == CNT_W'(PATTERN_IDS - 1)))) begin
          state_d = pend_q ? S_OUT : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          sym_d   = in_data_i.symbol;
          rsp_d   = '0;
          cnt_d   = '0;
          state_d = S_OUT;
          unique case (in_data_i.op)
            OP_CLEAR: begin
              ncount_d = (NW+1)'(1);
              ins_d    = '0;
              match_d  = '0;
              drop_d   = 1'b0;
              any_d    = 1'b0;
              full_d   = 1'b1;
              pend_d   = 1'b1;
              state_d  = S_CLR;
            end
            OP_PSYM: begin
              g_raddr = {ins_q, AW'(in_data_i.symbol)};
              if (drop_q) begin
                rsp_d.status = 1'b1;
              end else if (in_data_i.symbol < ALPHABET) begin
                state_d = S_PRD;
              end
            end
            OP_PEND: begin
              if (drop_q) begin
                rsp_d.status = 1'b1;
              end else begin
                np_we    = 1'b1;
                np_waddr = ins_q;
                np_wdata = {1'b1, in_data_i.pattern_id};
              end
              ins_d  = '0;
              drop_d = 1'b0;
            end
            OP_BUILD: begin
              fl_we   = 1'b1;
              head_d  = '0;
              tail_d  = '0;
              state_d = S_B0RD;
            end
            OP_TSTART: begin
              match_d = '0;
              any_d   = 1'b0;
              full_d  = 1'b0;
              pend_d  = 1'b1;
              state_d = S_CLR;
            end
            OP_TSYM: begin
              g_raddr = {match_q, AW'(in_data_i.symbol)};
              if (in_data_i.symbol < ALPHABET) begin
                state_d = S_TRD;
              end else begin
                match_d = '0;
              end
            end
            OP_QUERY: begin
              if (in_data_i.pattern_id < PATTERN_IDS) begin
                state_d = S_QRD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PRD: begin
        if (g_rdata[NW]) begin
          ins_d   = g_rdata[NW-1:0];
          state_d = S_OUT;
        end else if (ncount_q >= NODES) begin
          drop_d       = 1'b1;
          rsp_d.status = 1'b1;
          state_d      = S_OUT;
        end else begin
          // New node: link it from the parent, then fill its row with the root.
          g_we     = 1'b1;
          g_waddr  = {ins_q, AW'(sym_q)};
          g_wdata  = {1'b1, ncount_q[NW-1:0]};
          np_we    = 1'b1;
          np_waddr = ncount_q[NW-1:0];
          fl_we    = 1'b1;
          fl_waddr = ncount_q[NW-1:0];
          ins_d    = ncount_q[NW-1:0];
          ncount_d = ncount_q + 1'b1;
          state_d  = S_ALLOC;
        end
      end

      S_ALLOC: begin
        g_we    = 1'b1;
        g_waddr = {ins_q, cnt_sym};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ALPHABET - 1)) begin
          state_d = S_OUT;
        end
      end

      S_B0RD: begin
        g_raddr = {NW'(0), cnt_sym};
        state_d = S_B0EX;
      end

      S_B0EX: begin
        if (g_rdata[NW]) begin
          fl_we    = 1'b1;
          fl_waddr = g_rdata[NW-1:0];
          if (tail_q < NODES) begin
            q_we    = 1'b1;
            q_wdata = g_rdata[NW-1:0];
            tail_d  = tail_q + 1'b1;
          end
        end else begin
          g_we    = 1'b1;
          g_waddr = {NW'(0), cnt_sym};
        end
        if (cnt_q == CNT_W'(ALPHABET - 1)) begin
          state_d = S_BQRD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_B0RD;
        end
      end

      S_BQRD: begin
        if (head_q < tail_q) begin
          head_d  = head_q + 1'b1;
          state_d = S_BQEX;
        end else begin
          state_d = S_OUT;
        end
      end

      S_BQEX: begin
        u_d      = q_rdata;
        fl_raddr = q_rdata;
        state_d  = S_BFEX;
      end

      S_BFEX: begin
        f_d     = fl_rdata;
        cnt_d   = '0;
        state_d = S_BURD;
      end

      S_BURD: begin
        g_raddr = {u_q, cnt_sym};
        state_d = S_BFRD;
      end

      S_BFRD: begin
        e_d     = g_rdata;
        g_raddr = {f_q, cnt_sym};
        state_d = S_BEX;
      end

      S_BEX: begin
        // The failure node's row is already complete, so its entry is the target.
        if (e_q[NW]) begin
          fl_we    = 1'b1;
          fl_waddr = e_q[NW-1:0];
          fl_wdata = g_rdata[NW-1:0];
          if (tail_q < NODES) begin
            q_we    = 1'b1;
            q_wdata = e_q[NW-1:0];
            tail_d  = tail_q + 1'b1;
          end
        end else begin
          g_we    = 1'b1;
          g_waddr = {u_q, cnt_sym};
          g_wdata = {1'b0, g_rdata[NW-1:0]};
        end
        if (cnt_q == CNT_W'(ALPHABET - 1)) begin
          state_d = S_BQRD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_BURD;
        end
      end

      S_TRD: begin
        x_d     = g_rdata[NW-1:0];
        match_d = g_rdata[NW-1:0];
        steps_d = '0;
        found_d = 1'b0;
        state_d = S_WCHK;
      end

      S_WCHK: begin
        if ((x_q != '0) && (steps_q < NODES)) begin
          state_d = S_WEX;
        end else begin
          if (found_q) begin
            rsp_d.hit = 1'b1;
            any_d     = 1'b1;
          end
          state_d = S_OUT;
        end
      end

      S_WEX: begin
        if (np_rdata[PID_W]) begin
          found_d = 1'b1;
          if (np_rdata[PID_W-1:0] < PATTERN_IDS) begin
            s_we    = 1'b1;
            s_waddr = IW'(np_rdata[PID_W-1:0]);
            s_wdata = 1'b1;
          end
        end
        x_d     = fl_rdata;
        steps_d = steps_q + 1'b1;
        state_d = S_WCHK;
      end

      S_QRD: begin
        rsp_d.seen = s_rdata[0];
        state_d    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d           = rsp_q;
          out_d.any_match = any_q;
          out_valid_d     = 1'b1;
          pend_d          = 1'b0;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      sym_q       <= '0;
      ins_q       <= '0;
      match_q     <= '0;
      ncount_q    <= (NW+1)'(1);
      drop_q      <= 1'b0;
      any_q       <= 1'b0;
      full_q      <= 1'b1;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      u_q         <= '0;
      f_q         <= '0;
      e_q         <= '0;
      x_q         <= '0;
      steps_q     <= '0;
      found_q     <= 1'b0;
      rsp_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sym_q       <= sym_d;
      ins_q       <= ins_d;
      match_q     <= match_d;
      ncount_q    <= ncount_d;
      drop_q      <= drop_d;
      any_q       <= any_d;
      full_q      <= full_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      u_q         <= u_d;
      f_q         <= f_d;
      e_q         <= e_d;
      x_q         <= x_d;
      steps_q     <= steps_d;
      found_q     <= found_d;
      rsp_q       <= rsp_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  acm_ram #(.WIDTH(NW + 1), .DEPTH(GDEPTH)) u_goto (
    .clk_i(clk_i), .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );

  acm_ram #(.WIDTH(NPW), .DEPTH(NODES)) u_node_pat (
    .clk_i(clk_i), .we_i(np_we), .waddr_i(np_waddr), .wdata_i(np_wdata),
    .raddr_i(np_raddr), .rdata_o(np_rdata)
  );

  acm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
    .clk_i(clk_i), .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );

  acm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  acm_ram #(.WIDTH(1), .DEPTH(PATTERN_IDS)) u_seen (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // Every accepted op leaves the idle state in the next cycle.
  `ACM_ASSERT(a_fire_leaves_idle, in_fire |=> (state_q != S_IDLE), "op accepted but still idle")
  // A new node bumps the node count by exactly one.
  `ACM_ASSERT(a_alloc_count, alloc_start |=> (ncount_q == $past(ncount_q) + 1'b1), "bad count")
  // Results are only loaded from the result state.
  `ACM_ASSERT(a_out_source, $rose(out_valid_q) |-> ($past(state_q) == S_OUT), "bad result load")

endmodule

`default_nettype wire

>>> src/acm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module acm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
